// ===== src/vtp_pkg.sv =====
// Shared types, widths and helper functions for the vertex transform block.
// Depends on nothing; every other file refers to it by scoped names.
package vtp_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS = 16;
  localparam int COEFF_FRAC_BITS = 12;
  localparam int COORD_W = 32;
  localparam int COEFF_W = 16;
  localparam int ROW_W = 4 * COEFF_W;

  // Datapath widths
  localparam int PROD_W = COORD_W + COEFF_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int ACC_W = PROD_W + 2;
  localparam int T_W = ACC_W - COEFF_FRAC_BITS;
  localparam int QUOT_W = COORD_W;
  localparam int INIT_SHIFT = QUOT_W - COORD_FRAC_BITS;
  localparam int DIV_STEPS = QUOT_W;
  localparam int NUM_LANES = 3;

  // Queue between the front and back halves
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = ROW_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_DIV_EN = 3'd4
  } reg_index_t;

  localparam logic [ROW_W-1:0] ONE_COEFF = ROW_W'(1) << COEFF_FRAC_BITS;
  localparam logic [ROW_W-1:0] ROW0_RESET = ONE_COEFF;
  localparam logic [ROW_W-1:0] ROW1_RESET = ONE_COEFF << COEFF_W;
  localparam logic [ROW_W-1:0] ROW2_RESET = ONE_COEFF << (2 * COEFF_W);
  localparam logic [ROW_W-1:0] ROW3_RESET = ONE_COEFF << (3 * COEFF_W);

  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // One classified vertex, handed from the front half to the back half
  typedef struct packed {
    logic [NUM_LANES-1:0][T_W-1:0]     num_abs;
    logic [NUM_LANES-1:0]              neg;
    logic [T_W-1:0]                    den_abs;
    logic                              div_mode;
    logic                              dz;
    logic [NUM_LANES-1:0][COORD_W-1:0] plain;
    logic                              plain_sat;
    logic [COORD_W-1:0]                w;
    logic                              w_sat;
  } fe_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] val;
    logic               sat;
  } sat_t;

  // Clamp a full-width transformed component to the output format.
  function automatic sat_t sat32(input logic [T_W-1:0] v);
    logic [T_W-COORD_W:0] hi;
    sat_t r;
    hi = v[T_W-1:COORD_W-1];
    if ((&hi) || !(|hi)) begin
      r.val = v[COORD_W-1:0];
      r.sat = 1'b0;
    end else if (v[T_W-1]) begin
      r.val = SAT_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = SAT_MAX;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/vtp_if.sv =====
// Valid/ready channel interfaces for vertices in and transformed vertices out.
// Depends on vtp_pkg for the field widths.
interface vtp_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [vtp_pkg::COORD_W-1:0] in_x;
  logic signed [vtp_pkg::COORD_W-1:0] in_y;
  logic signed [vtp_pkg::COORD_W-1:0] in_z;
  logic signed [vtp_pkg::COORD_W-1:0] in_w;
  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vtp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vtp_pkg::COORD_W-1:0] out_x;
  logic signed [vtp_pkg::COORD_W-1:0] out_y;
  logic signed [vtp_pkg::COORD_W-1:0] out_z;
  logic signed [vtp_pkg::COORD_W-1:0] out_w;
  logic                               divide_by_zero;
  logic                               saturated;
  modport source (output valid, out_x, out_y, out_z, out_w, divide_by_zero, saturated,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, divide_by_zero, saturated,
                output ready);
endinterface

// ===== src/vtp_front.sv =====
// Front half: matrix multiply, rounding and classification of each vertex.
// Depends on vtp_pkg and vtp_in_if; feeds vtp_queue.
module vtp_front (
  input  logic                                  clk,
  input  logic                                  rst,
  vtp_in_if.sink                                in_ch,
  input  logic [3:0][vtp_pkg::ROW_W-1:0]        rows,
  input  logic                                  div_en,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output vtp_pkg::fe_item_t                     push_data
);

  localparam logic signed [vtp_pkg::ACC_W-1:0] ROUND =
    vtp_pkg::ACC_W'(1) <<< (vtp_pkg::COEFF_FRAC_BITS - 1);

  logic signed [vtp_pkg::COORD_W-1:0] vin [4];
  logic signed [vtp_pkg::PROD_W-1:0]  prod [4][4];
  logic signed [vtp_pkg::PAIR_W-1:0]  pair [4][2];
  logic signed [vtp_pkg::ACC_W-1:0]   acc [4];
  logic [vtp_pkg::T_W-1:0]            t [4];
  logic [3:0]                         sv;
  logic                               en;
  vtp_pkg::fe_item_t                  item_next;
  vtp_pkg::fe_item_t                  item;

  // The whole front advances unless a finished item cannot enter the queue.
  assign en = !(sv[3] && !push_ready);
  assign in_ch.ready = en;
  assign push_valid = sv[3];
  assign push_data = item;

  assign vin[0] = in_ch.in_x;
  assign vin[1] = in_ch.in_y;
  assign vin[2] = in_ch.in_z;
  assign vin[3] = in_ch.in_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (en) begin
      sv <= {sv[2:0], in_ch.valid};
    end
  end

  // First stage: sixteen products of a coordinate and a coefficient.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 4; c++) begin
          prod[i][c] <= vtp_pkg::PROD_W'(vin[i]) *
            vtp_pkg::PROD_W'($signed(rows[i][c*vtp_pkg::COEFF_W +: vtp_pkg::COEFF_W]));
        end
      end
    end
  end

  // Second stage: pairwise sums per column.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        pair[c][0] <= vtp_pkg::PAIR_W'(prod[0][c]) + vtp_pkg::PAIR_W'(prod[1][c]);
        pair[c][1] <= vtp_pkg::PAIR_W'(prod[2][c]) + vtp_pkg::PAIR_W'(prod[3][c]);
      end
    end
  end

  // Third stage: full column sum, rounded to nearest with ties upwards.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = vtp_pkg::ACC_W'(pair[c][0]) + vtp_pkg::ACC_W'(pair[c][1]) + ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        t[c] <= vtp_pkg::T_W'(acc[c] >>> vtp_pkg::COEFF_FRAC_BITS);
      end
    end
  end

  // Fourth stage: magnitudes and signs for the divider, plain clamped values.
  always_comb begin
    vtp_pkg::sat_t s;
    logic          any_sat;
    any_sat = 1'b0;
    for (int c = 0; c < vtp_pkg::NUM_LANES; c++) begin
      item_next.num_abs[c] = t[c][vtp_pkg::T_W-1] ? (~t[c] + 1'b1) : t[c];
      item_next.neg[c] = t[c][vtp_pkg::T_W-1] ^ t[3][vtp_pkg::T_W-1];
      s = vtp_pkg::sat32(t[c]);
      item_next.plain[c] = s.val;
      any_sat = any_sat | s.sat;
    end
    item_next.plain_sat = any_sat;
    item_next.den_abs = t[3][vtp_pkg::T_W-1] ? (~t[3] + 1'b1) : t[3];
    item_next.div_mode = div_en;
    item_next.dz = div_en && (t[3] == '0);
    s = vtp_pkg::sat32(t[3]);
    item_next.w = s.val;
    item_next.w_sat = s.sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule

// ===== src/vtp_queue.sv =====
// Short queue of classified vertices between the front and back halves.
// Depends on vtp_pkg for the item type and depth.
module vtp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  vtp_pkg::fe_item_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output vtp_pkg::fe_item_t pop_data
);

  vtp_pkg::fe_item_t           mem [vtp_pkg::FIFO_DEPTH];
  logic [vtp_pkg::FIFO_AW-1:0] wr_ptr;
  logic [vtp_pkg::FIFO_AW-1:0] rd_ptr;
  logic [vtp_pkg::FIFO_CW-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = (count != vtp_pkg::FIFO_CW'(vtp_pkg::FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  function automatic logic [vtp_pkg::FIFO_AW-1:0] ptr_inc(
    input logic [vtp_pkg::FIFO_AW-1:0] p);
    if (p == vtp_pkg::FIFO_AW'(vtp_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/vtp_back.sv =====
// Back half: pipelined restoring divide of x, y and z by w, then clamping.
// Depends on vtp_pkg and vtp_out_if; fed by vtp_queue.
module vtp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  vtp_pkg::fe_item_t pop_data,
  vtp_out_if.source         out_ch
);

  typedef struct packed {
    logic [vtp_pkg::NUM_LANES-1:0][vtp_pkg::T_W-1:0]    rem;
    logic [vtp_pkg::NUM_LANES-1:0][vtp_pkg::QUOT_W-1:0] qd;
    logic [vtp_pkg::NUM_LANES-1:0]                      ovf;
    vtp_pkg::fe_item_t                                  it;
  } bk_stage_t;

  bk_stage_t                      stg [vtp_pkg::DIV_STEPS+1];
  logic [vtp_pkg::DIV_STEPS:0]    sv;
  logic                           en;
  bk_stage_t                      load;
  logic [vtp_pkg::COORD_W-1:0]    res [4];
  logic                           res_dz;
  logic                           res_sat;

  assign en = !out_ch.valid || out_ch.ready;
  assign pop_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      sv <= {sv[vtp_pkg::DIV_STEPS-1:0], pop_valid};
      out_ch.valid <= sv[vtp_pkg::DIV_STEPS];
    end
  end

  // Load stage: initial remainder, dividend bits to shift in, overflow test.
  always_comb begin
    load.it = pop_data;
    for (int c = 0; c < vtp_pkg::NUM_LANES; c++) begin
      load.rem[c] = vtp_pkg::T_W'(pop_data.num_abs[c] >> vtp_pkg::INIT_SHIFT);
      load.qd[c] = vtp_pkg::QUOT_W'(pop_data.num_abs[c] << vtp_pkg::COORD_FRAC_BITS);
      load.ovf[c] = (load.rem[c] >= pop_data.den_abs);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= load;
    end
  end

  // One quotient bit per stage for every lane.
  for (genvar k = 1; k <= vtp_pkg::DIV_STEPS; k++) begin : g_step
    bk_stage_t nxt;
    always_comb begin
      logic [vtp_pkg::T_W:0] r2;
      logic                  qb;
      nxt = stg[k-1];
      for (int c = 0; c < vtp_pkg::NUM_LANES; c++) begin
        r2 = {stg[k-1].rem[c], stg[k-1].qd[c][vtp_pkg::QUOT_W-1]};
        qb = (r2 >= {1'b0, stg[k-1].it.den_abs});
        if (qb) begin
          r2 = r2 - {1'b0, stg[k-1].it.den_abs};
        end
        nxt.rem[c] = r2[vtp_pkg::T_W-1:0];
        nxt.qd[c] = {stg[k-1].qd[c][vtp_pkg::QUOT_W-2:0], qb};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= nxt;
      end
    end
  end

  // Final selection: signed quotient with clamping, zero on a zero divisor, or the plain values.
  always_comb begin
    bk_stage_t                  f;
    logic [vtp_pkg::QUOT_W-1:0] q;
    logic                       q_top;
    logic                       q_rest;
    logic                       any_sat;
    f = stg[vtp_pkg::DIV_STEPS];
    any_sat = f.it.w_sat;
    res[3] = f.it.w;
    res_dz = f.it.dz;
    for (int c = 0; c < vtp_pkg::NUM_LANES; c++) begin
      q = f.qd[c];
      q_top = q[vtp_pkg::QUOT_W-1];
      q_rest = |q[vtp_pkg::QUOT_W-2:0];
      if (!f.it.div_mode) begin
        res[c] = f.it.plain[c];
      end else if (f.it.dz) begin
        res[c] = '0;
      end else if (f.it.neg[c]) begin
        if (f.ovf[c] || (q_top && q_rest)) begin
          res[c] = vtp_pkg::SAT_MIN;
          any_sat = 1'b1;
        end else begin
          res[c] = ~q + 1'b1;
        end
      end else if (f.ovf[c] || q_top) begin
        res[c] = vtp_pkg::SAT_MAX;
        any_sat = 1'b1;
      end else begin
        res[c] = q;
      end
    end
    if (!f.it.div_mode) begin
      any_sat = any_sat | f.it.plain_sat;
    end
    res_sat = any_sat;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.out_x <= res[0];
      out_ch.out_y <= res[1];
      out_ch.out_z <= res[2];
      out_ch.out_w <= res[3];
      out_ch.divide_by_zero <= res_dz;
      out_ch.saturated <= res_sat;
    end
  end

endmodule

// ===== src/vertex_transform_perspective_core.sv =====
// Vertex transform with optional perspective divide: the top level.
// Depends on vtp_pkg, vtp_if, vtp_front, vtp_queue and vtp_back.
//
// Vertices arrive on in_ch, a valid/ready channel; a transfer takes place at a
// rising edge with valid and ready both high. Results leave on out_ch with the
// same handshake, one result per vertex and in order.
// The matrix rows and the divide mode are written through wr_en, wr_index and
// wr_data; the user must do so only while the block is idle, which the block
// itself does not enforce. An index beyond the register list is ignored.
// From the input transfer to result valid, a vertex passes four front stages
// (products, registered at the transfer edge itself, then pair sums, rounded
// column sums and classification), the queue, a load stage, 32 divider stages
// (one quotient bit each) and the output register. Throughput is one vertex
// per clock when nothing stalls, set by the fully pipelined multipliers and
// divider.
// Synchronous reset empties the pipeline and queue and restores the identity
// matrix with divide mode on.
// When the receiver stalls, the back half holds and the front half keeps
// taking vertices until the two-entry queue and its own stages are full.
module vertex_transform_perspective_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [vtp_pkg::CFG_DATA_W-1:0]    wr_data,
  vtp_in_if.sink                            in_ch,
  vtp_out_if.source                         out_ch
);

  logic [3:0][vtp_pkg::ROW_W-1:0] rows;
  logic                           div_en;
  logic                           push_valid;
  logic                           push_ready;
  vtp_pkg::fe_item_t              push_data;
  logic                           pop_valid;
  logic                           pop_ready;
  vtp_pkg::fe_item_t              pop_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= vtp_pkg::ROW0_RESET;
      rows[1] <= vtp_pkg::ROW1_RESET;
      rows[2] <= vtp_pkg::ROW2_RESET;
      rows[3] <= vtp_pkg::ROW3_RESET;
      div_en <= 1'b1;
    end else if (wr_en) begin
      case (vtp_pkg::reg_index_t'(wr_index))
        vtp_pkg::REG_ROW0:   rows[0] <= wr_data;
        vtp_pkg::REG_ROW1:   rows[1] <= wr_data;
        vtp_pkg::REG_ROW2:   rows[2] <= wr_data;
        vtp_pkg::REG_ROW3:   rows[3] <= wr_data;
        vtp_pkg::REG_DIV_EN: div_en <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  vtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .rows       (rows),
    .div_en     (div_en),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  vtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  vtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
// Testbench for vertex_transform_perspective_core: drives vertices through the
// valid/ready channels, predicts each transformed vertex and checks it in order.
// Depends on vtp_pkg, vtp_if and the core RTL.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [31:0] x, y, z, w;
    logic        dz, sat;
  } vertex_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [vtp_pkg::CFG_IDX_W-1:0] wr_index = '0;
  logic [vtp_pkg::CFG_DATA_W-1:0] wr_data = '0;

  vtp_in_if in_ch();
  vtp_out_if out_ch();

  vertex_transform_perspective_core dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the configuration registers.
  logic [63:0] mat_row [4];
  logic        div_on;

  vertex_res_t pending_vertices[$];
  int  errors = 0;
  bit  hold_off = 1'b0;
  bit  sink_quiet = 1'b0;

  // Clamp to Q16.16, noting a clamp in the flag.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Work out the transformed vertex for one input.
  function automatic vertex_res_t transform_vertex(input logic [31:0] vx, vy, vz, vw);
    logic signed [127:0] vin [4];
    logic signed [127:0] tc [4];
    logic signed [127:0] acc, coef, q;
    vertex_res_t r;
    logic s;
    vin[0] = $signed(vx); vin[1] = $signed(vy);
    vin[2] = $signed(vz); vin[3] = $signed(vw);
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        coef = $signed(mat_row[i][16*c +: 16]);
        acc += vin[i] * coef;
      end
      acc += 128'sd2048;
      tc[c] = acc >>> vtp_pkg::COEFF_FRAC_BITS;
    end
    s = 1'b0;
    r.dz = 1'b0;
    r.w = clamp32(tc[3], s);
    if (div_on && tc[3] == 0) begin
      r.dz = 1'b1;
      r.x = '0; r.y = '0; r.z = '0;
    end else if (div_on) begin
      // Signed division in SystemVerilog truncates toward zero.
      q = (tc[0] <<< vtp_pkg::COORD_FRAC_BITS) / tc[3]; r.x = clamp32(q, s);
      q = (tc[1] <<< vtp_pkg::COORD_FRAC_BITS) / tc[3]; r.y = clamp32(q, s);
      q = (tc[2] <<< vtp_pkg::COORD_FRAC_BITS) / tc[3]; r.z = clamp32(q, s);
    end else begin
      r.x = clamp32(tc[0], s);
      r.y = clamp32(tc[1], s);
      r.z = clamp32(tc[2], s);
    end
    r.sat = s;
    return r;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
           (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
  endfunction

  // Write one register while idle.
  task automatic write_reg(input vtp_pkg::reg_index_t idx, input logic [63:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      vtp_pkg::REG_ROW0: mat_row[0] = val;
      vtp_pkg::REG_ROW1: mat_row[1] = val;
      vtp_pkg::REG_ROW2: mat_row[2] = val;
      vtp_pkg::REG_ROW3: mat_row[3] = val;
      vtp_pkg::REG_DIV_EN: div_on = val[0];
      default: ;
    endcase
  endtask

  // Write an index beyond the register list; it must change nothing.
  task automatic write_bad_index();
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = 3'd7;
    wr_data = '1;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // Offer one vertex and wait for its transfer.
  task automatic send_vertex(input logic [31:0] vx, vy, vz, vw, input bit gaps = 1);
    if (gaps) repeat (short_gap()) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.in_x = vx; in_ch.in_y = vy; in_ch.in_z = vz; in_ch.in_w = vw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_vertices.push_back(transform_vertex(vx, vy, vz, vw));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_vertices.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Coefficient row of modest values around the identity.
  function automatic logic [63:0] mild_row(input int diag);
    logic [63:0] r;
    for (int c = 0; c < 4; c++)
      r[16*c +: 16] = (c == diag) ? 16'(4096 + $urandom_range(0, 2048) - 1024)
                                  : 16'($urandom_range(0, 1024) - 512);
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'h80000000 + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  // Result checker.
  always @(posedge clk) begin
    vertex_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected result x=%h", out_ch.out_x);
        errors++;
      end else begin
        e = pending_vertices.pop_front();
        if (out_ch.out_x !== e.x) begin
          $error("out_x exp %h got %h", e.x, out_ch.out_x); errors++;
        end
        if (out_ch.out_y !== e.y) begin
          $error("out_y exp %h got %h", e.y, out_ch.out_y); errors++;
        end
        if (out_ch.out_z !== e.z) begin
          $error("out_z exp %h got %h", e.z, out_ch.out_z); errors++;
        end
        if (out_ch.out_w !== e.w) begin
          $error("out_w exp %h got %h", e.w, out_ch.out_w); errors++;
        end
        if (out_ch.divide_by_zero !== e.dz) begin
          $error("divide_by_zero exp %b got %b", e.dz, out_ch.divide_by_zero); errors++;
        end
        if (out_ch.saturated !== e.sat) begin
          $error("saturated exp %b got %b", e.sat, out_ch.saturated); errors++;
        end
      end
    end
  end

  // Receiver readiness: random stalls, a quiet stretch, or a long hold-off.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready = 1'b0;
        for (int k = 0; k < 200; k++) @(negedge clk);
        hold_off = 1'b0;
      end else if (sink_quiet) begin
        out_ch.ready = 1'b1;
      end else begin
        n = short_gap();
        out_ch.ready = (n == 0);
        if (n != 0) repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Extremes of the fields, a zero divisor and saturation.
  task automatic test_directed();
    send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000);
    send_vertex(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00000001);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h0, 32'h80000000);
    send_vertex(32'h00010000, 32'h0, 32'h0, 32'h0);
    send_vertex(32'h0, 32'h0, 32'h0, 32'h0);
    send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_vertex(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    drain();
    write_reg(vtp_pkg::REG_DIV_EN, 64'h0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h12345678, 32'h0);
    send_vertex(32'haaaaaaaa, 32'h55555555, 32'h0, 32'h80000000);
    drain();
    // Extreme coefficients in the first two rows, minus one in the third and zero in the fourth.
    write_reg(vtp_pkg::REG_ROW0, 64'h7fff_8000_7fff_8000);
    write_reg(vtp_pkg::REG_ROW1, 64'h8000_7fff_8000_7fff);
    write_reg(vtp_pkg::REG_ROW2, 64'hffff_ffff_ffff_ffff);
    write_reg(vtp_pkg::REG_ROW3, 64'h0000_0000_0000_0000);
    write_bad_index();
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_vertex(32'h00000800, 32'hfffff800, 32'h1, 32'h0);
    drain();
    write_reg(vtp_pkg::REG_DIV_EN, 64'hffff_ffff_ffff_fffe);
    send_vertex(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
    drain();
    write_reg(vtp_pkg::REG_DIV_EN, 64'h3);
    send_vertex(32'h00010000, 32'h7fffffff, 32'h00010000, 32'h00010000);
    drain();
  endtask

  // Random vertices under one matrix and mode.
  task automatic test_random_phase(input int count, input bit wild);
    for (int r = 0; r < 4; r++)
      write_reg(vtp_pkg::reg_index_t'(r), wild ? rand64() : mild_row(r));
    write_reg(vtp_pkg::REG_DIV_EN, 64'($urandom_range(0, 1)));
    for (int k = 0; k < count; k++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(0, 15) == 0) ? 32'h0 : rand_coord());
    drain();
  endtask

  // Receiver holds off while the sender keeps offering, then an always-ready receiver.
  // The hold-off sends more vertices than the block can hold, so the input stalls.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int k = 0; k < 60; k++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0);
    drain();
    sink_quiet = 1'b1;
    for (int k = 0; k < 40; k++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0);
    sink_quiet = 1'b0;
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_x = '0; in_ch.in_y = '0; in_ch.in_z = '0; in_ch.in_w = '0;
    mat_row[0] = vtp_pkg::ROW0_RESET; mat_row[1] = vtp_pkg::ROW1_RESET;
    mat_row[2] = vtp_pkg::ROW2_RESET; mat_row[3] = vtp_pkg::ROW3_RESET;
    div_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    for (int p = 0; p < 8; p++)
      test_random_phase(50, p % 3 == 2);
    test_backpressure();
    if (errors == 0 && pending_vertices.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
